FILE: rtl/pan_tilt_aim_controller_assert.svh
// assertion macros used by the checker file
`ifndef PAN_TILT_AIM_CONTROLLER_ASSERT_SVH
`define PAN_TILT_AIM_CONTROLLER_ASSERT_SVH

// same-cycle implication, masked while reset is low
`define PTAC_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("ptac assertion failed");

// next-cycle implication, masked while reset is low
`define PTAC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("ptac assertion failed");

`endif

FILE: rtl/ptac_pkg.sv
package ptac_pkg;

    localparam int ERROR_WIDTH    = 16;
    localparam int GAIN_FRAC_BITS = 8;

    localparam int ANGLE_W   = 8;
    localparam int GAIN_W    = 8;
    localparam int DUR_W     = 16;
    localparam int ELAPSED_W = 17;

    // err * gain, gain taken as a positive signed value
    localparam int PROD_W = ERROR_WIDTH + GAIN_W + 1;
    // pos scaled up by the gain fraction, as a signed value
    localparam int POS_W  = ANGLE_W + GAIN_FRAC_BITS + 1;
    localparam int CALC_W = ((POS_W > PROD_W) ? POS_W : PROD_W) + 1;

    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;
    localparam int IDX_W  = 3;

    localparam logic [1:0] ACT_TICK   = 2'd0;
    localparam logic [1:0] ACT_FIRE   = 2'd1;
    localparam logic [1:0] ACT_MOVE   = 2'd2;
    localparam logic [1:0] ACT_TARGET = 2'd3;

    localparam logic [2:0] DIR_UP    = 3'd0;
    localparam logic [2:0] DIR_DOWN  = 3'd1;
    localparam logic [2:0] DIR_LEFT  = 3'd2;
    localparam logic [2:0] DIR_RIGHT = 3'd3;

    localparam logic [IDX_W-1:0] REG_PAN_GAIN      = 3'd0;
    localparam logic [IDX_W-1:0] REG_TILT_GAIN     = 3'd1;
    localparam logic [IDX_W-1:0] REG_MANUAL_STEP   = 3'd2;
    localparam logic [IDX_W-1:0] REG_FIRE_DURATION = 3'd3;
    localparam logic [IDX_W-1:0] REG_PAN_LOWER     = 3'd4;
    localparam logic [IDX_W-1:0] REG_PAN_UPPER     = 3'd5;
    localparam logic [IDX_W-1:0] REG_TILT_LOWER    = 3'd6;
    localparam logic [IDX_W-1:0] REG_TILT_UPPER    = 3'd7;

    localparam logic [GAIN_W-1:0]  RST_PAN_GAIN      = 8'd31;
    localparam logic [GAIN_W-1:0]  RST_TILT_GAIN     = 8'd31;
    localparam logic [ANGLE_W-1:0] RST_MANUAL_STEP   = 8'd5;
    localparam logic [DUR_W-1:0]   RST_FIRE_DURATION = 16'd500;
    localparam logic [ANGLE_W-1:0] RST_PAN_LOWER     = 8'd0;
    localparam logic [ANGLE_W-1:0] RST_PAN_UPPER     = 8'd180;
    localparam logic [ANGLE_W-1:0] RST_TILT_LOWER    = 8'd20;
    localparam logic [ANGLE_W-1:0] RST_TILT_UPPER    = 8'd160;
    localparam logic [ANGLE_W-1:0] RST_POSITION      = 8'd90;

    typedef logic signed [CALC_W-1:0] calc_t;

    // upper limit first, lower limit second
    function automatic logic [ANGLE_W-1:0] clamp_angle(calc_t p, logic [ANGLE_W-1:0] lo,
                                                       logic [ANGLE_W-1:0] hi);
        calc_t v;
        calc_t lo_s;
        calc_t hi_s;
        lo_s = signed'(CALC_W'(lo));
        hi_s = signed'(CALC_W'(hi));
        v = p;
        if (v > hi_s) v = hi_s;
        if (v < lo_s) v = lo_s;
        return v[ANGLE_W-1:0];
    endfunction

    // (pos * 2^frac - err * gain) / 2^frac, quotient truncated toward zero
    function automatic calc_t correct(logic [ANGLE_W-1:0] pos,
                                      logic signed [ERROR_WIDTH-1:0] err,
                                      logic [GAIN_W-1:0] gain);
        logic signed [PROD_W-1:0] prod;
        calc_t t;
        calc_t q;
        prod = err * signed'({1'b0, gain});
        t = signed'(CALC_W'({pos, {GAIN_FRAC_BITS{1'b0}}})) - CALC_W'(prod);
        q = t >>> GAIN_FRAC_BITS;
        if (t[CALC_W-1] && (t[GAIN_FRAC_BITS-1:0] != '0)) q = q + signed'(CALC_W'(1));
        return q;
    endfunction

endpackage

FILE: rtl/pan_tilt_aim_controller.sv
// channel   direction  ports                                          handshake
// config    in/out     psel penable pwrite paddr pwdata prdata pready  apb, pready tied high
// command   in         s_action s_direction s_error_x s_error_y        s_valid / s_ready
// result    out        m_pan_angle m_tilt_angle m_trigger
//                      m_fire_began m_fire_ended                      m_valid / m_ready
//
// path: a command is registered in the input register, then in the result register; a stall can hold it between
// throughput: one word per cycle while results are drained, set by the single update path between the two registers
// reset: synchronous, active low; angles go to 90, trigger idle, registers to defaults
// stalls: a held result parks in the result register while the next command waits in
//   the input register; the state only advances when a command moves into the result register
module pan_tilt_aim_controller import ptac_pkg::*; (
    input  logic                          aclk,
    input  logic                          aresetn,
    // config port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ADDR_W-1:0]             paddr,
    input  logic [DATA_W-1:0]             pwdata,
    output logic [DATA_W-1:0]             prdata,
    output logic                          pready,
    // command channel
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_action,
    input  logic [2:0]                    s_direction,
    input  logic signed [ERROR_WIDTH-1:0] s_error_x,
    input  logic signed [ERROR_WIDTH-1:0] s_error_y,
    // result channel
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [ANGLE_W-1:0]            m_pan_angle,
    output logic [ANGLE_W-1:0]            m_tilt_angle,
    output logic                          m_trigger,
    output logic                          m_fire_began,
    output logic                          m_fire_ended
);

    // configuration registers
    logic [GAIN_W-1:0]  pan_gain_reg;
    logic [GAIN_W-1:0]  tilt_gain_reg;
    logic [ANGLE_W-1:0] manual_step_reg;
    logic [DUR_W-1:0]   fire_duration_reg;
    logic [ANGLE_W-1:0] pan_lower_reg;
    logic [ANGLE_W-1:0] pan_upper_reg;
    logic [ANGLE_W-1:0] tilt_lower_reg;
    logic [ANGLE_W-1:0] tilt_upper_reg;

    // aim state
    logic [ANGLE_W-1:0]   pan_pos_reg;
    logic [ANGLE_W-1:0]   tilt_pos_reg;
    logic                 firing_reg;
    logic [ELAPSED_W-1:0] elapsed_reg;
    logic [ANGLE_W-1:0]   pan_pos_next;
    logic [ANGLE_W-1:0]   tilt_pos_next;
    logic                 firing_next;
    logic [ELAPSED_W-1:0] elapsed_next;

    // input register
    logic                          in_valid_reg;
    logic [1:0]                    in_action_reg;
    logic [2:0]                    in_dir_reg;
    logic signed [ERROR_WIDTH-1:0] in_ex_reg;
    logic signed [ERROR_WIDTH-1:0] in_ey_reg;

    // result register
    logic               out_valid_reg;
    logic [ANGLE_W-1:0] out_pan_reg;
    logic [ANGLE_W-1:0] out_tilt_reg;
    logic               out_trigger_reg;
    logic               out_began_reg;
    logic               out_ended_reg;

    logic                 cfg_wr;
    logic [IDX_W-1:0]     cfg_idx;
    logic                 out_free;
    logic                 commit;
    logic                 began;
    logic                 ended;
    logic                 aim_update;
    logic [ELAPSED_W-1:0] elapsed_inc;
    calc_t                pan_calc;
    calc_t                tilt_calc;
    calc_t                step_s;

    // ---------------- config port ----------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[ADDR_W-1:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pan_gain_reg      <= RST_PAN_GAIN;
            tilt_gain_reg     <= RST_TILT_GAIN;
            manual_step_reg   <= RST_MANUAL_STEP;
            fire_duration_reg <= RST_FIRE_DURATION;
            pan_lower_reg     <= RST_PAN_LOWER;
            pan_upper_reg     <= RST_PAN_UPPER;
            tilt_lower_reg    <= RST_TILT_LOWER;
            tilt_upper_reg    <= RST_TILT_UPPER;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_PAN_GAIN:      pan_gain_reg      <= pwdata[GAIN_W-1:0];
                REG_TILT_GAIN:     tilt_gain_reg     <= pwdata[GAIN_W-1:0];
                REG_MANUAL_STEP:   manual_step_reg   <= pwdata[ANGLE_W-1:0];
                REG_FIRE_DURATION: fire_duration_reg <= pwdata[DUR_W-1:0];
                REG_PAN_LOWER:     pan_lower_reg     <= pwdata[ANGLE_W-1:0];
                REG_PAN_UPPER:     pan_upper_reg     <= pwdata[ANGLE_W-1:0];
                REG_TILT_LOWER:    tilt_lower_reg    <= pwdata[ANGLE_W-1:0];
                REG_TILT_UPPER:    tilt_upper_reg    <= pwdata[ANGLE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // register readback, zero filled above each field
    always_comb begin
        case (cfg_idx)
            REG_PAN_GAIN:      prdata = DATA_W'(pan_gain_reg);
            REG_TILT_GAIN:     prdata = DATA_W'(tilt_gain_reg);
            REG_MANUAL_STEP:   prdata = DATA_W'(manual_step_reg);
            REG_FIRE_DURATION: prdata = DATA_W'(fire_duration_reg);
            REG_PAN_LOWER:     prdata = DATA_W'(pan_lower_reg);
            REG_PAN_UPPER:     prdata = DATA_W'(pan_upper_reg);
            REG_TILT_LOWER:    prdata = DATA_W'(tilt_lower_reg);
            REG_TILT_UPPER:    prdata = DATA_W'(tilt_upper_reg);
            default:           prdata = '0;
        endcase
    end

    // ---------------- pipeline control ----------------
    // the result register frees up when empty or being drained this cycle
    assign out_free = !out_valid_reg || m_ready;
    // a command leaves the input register, and its effect lands in the state
    assign commit   = in_valid_reg && out_free;
    // the input register takes a new word when empty or emptying
    assign s_ready  = !in_valid_reg || out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_action_reg <= s_action;
            in_dir_reg    <= s_direction;
            in_ex_reg     <= s_error_x;
            in_ey_reg     <= s_error_y;
        end
    end

    // ---------------- command update ----------------
    assign elapsed_inc = elapsed_reg + ELAPSED_W'(1);
    assign step_s      = signed'(CALC_W'(manual_step_reg));

    always_comb begin
        firing_next  = firing_reg;
        elapsed_next = elapsed_reg;
        began        = 1'b0;
        ended        = 1'b0;
        aim_update   = 1'b0;
        pan_calc     = signed'(CALC_W'(pan_pos_reg));
        tilt_calc    = signed'(CALC_W'(tilt_pos_reg));
        case (in_action_reg)
            ACT_TICK: begin
                // pulse runs until the count passes the duration
                if (firing_reg) begin
                    elapsed_next = elapsed_inc;
                    if (elapsed_inc > ELAPSED_W'(fire_duration_reg)) begin
                        firing_next  = 1'b0;
                        elapsed_next = '0;
                        ended        = 1'b1;
                    end
                end
            end
            ACT_FIRE: begin
                // a fire during a running pulse is dropped
                if (!firing_reg) begin
                    firing_next  = 1'b1;
                    elapsed_next = '0;
                    began        = 1'b1;
                end
            end
            ACT_MOVE: begin
                aim_update = 1'b1;
                case (in_dir_reg)
                    DIR_UP:    tilt_calc = tilt_calc + step_s;
                    DIR_DOWN:  tilt_calc = tilt_calc - step_s;
                    DIR_LEFT:  pan_calc  = pan_calc + step_s;
                    DIR_RIGHT: pan_calc  = pan_calc - step_s;
                    default: begin
                        // unknown direction: clamp only
                    end
                endcase
            end
            ACT_TARGET: begin
                aim_update = 1'b1;
                pan_calc   = correct(pan_pos_reg, in_ex_reg, pan_gain_reg);
                tilt_calc  = correct(tilt_pos_reg, in_ey_reg, tilt_gain_reg);
            end
            default: begin
            end
        endcase
    end

    assign pan_pos_next  = aim_update ? clamp_angle(pan_calc, pan_lower_reg, pan_upper_reg)
                                      : pan_pos_reg;
    assign tilt_pos_next = aim_update ? clamp_angle(tilt_calc, tilt_lower_reg, tilt_upper_reg)
                                      : tilt_pos_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pan_pos_reg  <= RST_POSITION;
            tilt_pos_reg <= RST_POSITION;
            firing_reg   <= 1'b0;
            elapsed_reg  <= '0;
        end else if (commit) begin
            pan_pos_reg  <= pan_pos_next;
            tilt_pos_reg <= tilt_pos_next;
            firing_reg   <= firing_next;
            elapsed_reg  <= elapsed_next;
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (commit) begin
            out_pan_reg     <= pan_pos_next;
            out_tilt_reg    <= tilt_pos_next;
            out_trigger_reg <= firing_next;
            out_began_reg   <= began;
            out_ended_reg   <= ended;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_pan_angle  = out_pan_reg;
    assign m_tilt_angle = out_tilt_reg;
    assign m_trigger    = out_trigger_reg;
    assign m_fire_began = out_began_reg;
    assign m_fire_ended = out_ended_reg;

endmodule

FILE: rtl/ptac_checker.sv
`include "pan_tilt_aim_controller_assert.svh"

module ptac_checker import ptac_pkg::*; (
    input logic               aclk,
    input logic               aresetn,
    input logic               m_valid,
    input logic               m_ready,
    input logic [ANGLE_W-1:0] m_pan_angle,
    input logic [ANGLE_W-1:0] m_tilt_angle,
    input logic               m_trigger,
    input logic               m_fire_began,
    input logic               m_fire_ended
);

    logic                   stalled;
    logic [2*ANGLE_W+2:0]   res_word;

    assign stalled  = m_valid && !m_ready;
    assign res_word = {m_pan_angle, m_tilt_angle, m_trigger, m_fire_began, m_fire_ended};

    // a word cannot both start and release a pulse
    `PTAC_ASSERT_NOW(a_began_ended_excl, aclk, aresetn, m_valid, !(m_fire_began && m_fire_ended))

    // a started pulse shows the trigger held
    `PTAC_ASSERT_NOW(a_began_trigger, aclk, aresetn, m_valid && m_fire_began, m_trigger)

    // a released pulse shows the trigger dropped
    `PTAC_ASSERT_NOW(a_ended_trigger, aclk, aresetn, m_valid && m_fire_ended, !m_trigger)

    // a stalled result stays put
    `PTAC_ASSERT_NEXT(a_result_hold, aclk, aresetn, stalled, m_valid && $stable(res_word))

endmodule

bind pan_tilt_aim_controller ptac_checker u_ptac_checker (.*);
